[src/ljn_pkg.sv]
// ----------------------------------------------------------------------------
// ljn_pkg - shared types and tables of the limb normalizer
// Angle ranges per limb, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ljn_pkg;

	// default limb count and item layout
	localparam int NUM_LIMBS_DEF = 10;
	localparam int LIMB_W        = 4;
	localparam int SAMPLE_W      = 16;
	localparam int POS_W         = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int TDATA_W       = 24;
	localparam int RANGE_W       = 9;

	// register reset values
	localparam logic [CFG_W-1:0] JUMP_RESET     = 16'd60;
	localparam logic [CFG_W-1:0] DEADBAND_RESET = 16'd3;

	// reciprocal of three, exact for 16 bit dividends with a 17 bit shift
	localparam logic [16:0] RECIP3 = 17'd43691;

	// quotient bits produced by the divider
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JUMP_THRESHOLD = 1'b0,
		REG_DEADBAND       = 1'b1
	} reg_index_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_PULL,
		ST_TARGET,
		ST_MAG,
		ST_NUM,
		ST_DIV,
		ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic ld_in;
		logic ld_first;
		logic ld_dist;
		logic ld_quot;
		logic ld_target;
		logic ld_rest;
		logic div_init;
		logic div_step;
		logic ld_out;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic limb_ok;
		logic seen;
		logic db_pass;
	} dp_status_t;

	// lower angle bound of a limb
	function automatic logic signed [RANGE_W-1:0] angle_lo(input logic [LIMB_W-1:0] idx);
		logic signed [RANGE_W-1:0] lo;
		case (idx)
			4'd0:    lo = -9'sd90;
			4'd1:    lo = -9'sd60;
			4'd4:    lo = -9'sd80;
			4'd5:    lo = -9'sd28;
			default: lo = 9'sd0;
		endcase
		return lo;
	endfunction

	// span max - min of a limb
	function automatic logic [RANGE_W-1:0] angle_range(input logic [LIMB_W-1:0] idx);
		logic [RANGE_W-1:0] rng;
		case (idx)
			4'd0:    rng = 9'd180;
			4'd1:    rng = 9'd120;
			4'd2:    rng = 9'd30;
			4'd3:    rng = 9'd50;
			4'd4:    rng = 9'd160;
			4'd5:    rng = 9'd56;
			4'd7:    rng = 9'd230;
			4'd9:    rng = 9'd60;
			default: rng = 9'd300;
		endcase
		return rng;
	endfunction

endpackage

[src/ljn_ctrl.sv]
// ----------------------------------------------------------------------------
// ljn_ctrl - sequencing of one item through the datapath
// Handles the input and output handshakes and steps the datapath through
// distance, pull, update, clamp and the shift-subtract divider.
// ----------------------------------------------------------------------------
module ljn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ljn_pkg::dp_status_t  status,
	output ljn_pkg::dp_cmd_t     cmd
);

	ljn_pkg::state_t                state_q, state_d;
	logic [ljn_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic                           out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ljn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ljn_pkg::ST_DIV) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end else begin
			div_cnt_q <= '0;
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ljn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ljn_pkg::ST_DIST;
				end
			end
			ljn_pkg::ST_DIST: begin
				if (!status.limb_ok) begin
					state_d = ljn_pkg::ST_IDLE;
				end else if (!status.seen) begin
					cmd.ld_first = 1'b1;
					state_d      = ljn_pkg::ST_IDLE;
				end else begin
					cmd.ld_dist = 1'b1;
					state_d     = ljn_pkg::ST_PULL;
				end
			end
			ljn_pkg::ST_PULL: begin
				cmd.ld_quot = 1'b1;
				state_d     = ljn_pkg::ST_TARGET;
			end
			ljn_pkg::ST_TARGET: begin
				if (status.db_pass) begin
					cmd.ld_target = 1'b1;
					state_d       = ljn_pkg::ST_MAG;
				end else begin
					state_d = ljn_pkg::ST_IDLE;
				end
			end
			ljn_pkg::ST_MAG: begin
				cmd.ld_rest = 1'b1;
				state_d     = ljn_pkg::ST_NUM;
			end
			ljn_pkg::ST_NUM: begin
				cmd.div_init = 1'b1;
				state_d      = ljn_pkg::ST_DIV;
			end
			ljn_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == ljn_pkg::DIV_CNT_W'(ljn_pkg::DIV_STEPS - 1)) begin
					state_d = ljn_pkg::ST_OUT;
				end
			end
			ljn_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.ld_out = 1'b1;
					state_d    = ljn_pkg::ST_IDLE;
				end
			end
		endcase
	end

endmodule

[src/ljn_dpath.sv]
// ----------------------------------------------------------------------------
// ljn_dpath - per-limb state, jump limit, deadband and normalizing divider
// Holds the configuration registers, the kept value and seen flag of each
// limb, and the arithmetic stages that the controller steps through.
// ----------------------------------------------------------------------------
module ljn_dpath #(
	parameter int NUM_LIMBS = ljn_pkg::NUM_LIMBS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ljn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ljn_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [ljn_pkg::TDATA_W-1:0]       in_data,
	output logic [ljn_pkg::TDATA_W-1:0]       out_data,
	input  ljn_pkg::dp_cmd_t                  cmd,
	output ljn_pkg::dp_status_t               status
);

	localparam int IDXW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;
	localparam logic [ljn_pkg::LIMB_W:0] LIMB_CNT = (ljn_pkg::LIMB_W + 1)'(NUM_LIMBS);

	// configuration
	logic [ljn_pkg::CFG_W-1:0]           jump_q;
	logic [ljn_pkg::CFG_W-1:0]           deadband_q;

	// per-limb state
	logic [NUM_LIMBS-1:0]                seen_q;
	logic signed [ljn_pkg::SAMPLE_W-1:0] kept_mem [NUM_LIMBS];

	// item registers
	logic [ljn_pkg::LIMB_W-1:0]          limb_q;
	logic signed [ljn_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [ljn_pkg::SAMPLE_W-1:0] kept_q;
	logic                                dir_q;
	logic [15:0]                         dist_q;
	logic [15:0]                         quot_q;
	logic signed [ljn_pkg::SAMPLE_W-1:0] target_q;
	logic [ljn_pkg::RANGE_W-1:0]         rest_q;
	logic [ljn_pkg::RANGE_W-1:0]         rem_q;
	logic [ljn_pkg::POS_W-1:0]           quo_q;
	logic [ljn_pkg::LIMB_W-1:0]          out_limb_q;
	logic [ljn_pkg::POS_W-1:0]           out_pos_q;

	// combinational values
	logic [IDXW-1:0]                     idx;
	logic                                limb_ok;
	logic signed [ljn_pkg::SAMPLE_W-1:0] kept_rd;
	logic signed [16:0]                  diff;
	logic signed [16:0]                  diff_neg;
	logic [32:0]                         prod;
	logic signed [ljn_pkg::SAMPLE_W-1:0] target_d;
	logic signed [ljn_pkg::RANGE_W-1:0]  lo;
	logic [ljn_pkg::RANGE_W-1:0]         rng;
	logic signed [16:0]                  mag_diff;
	logic signed [16:0]                  rng_ext;
	logic [ljn_pkg::RANGE_W-1:0]         rest_d;
	logic [23:0]                         num;
	logic [10:0]                         trial;

	assign idx     = limb_q[IDXW-1:0];
	assign limb_ok = ({1'b0, limb_q} < LIMB_CNT);
	assign kept_rd = kept_mem[idx];
	assign lo      = ljn_pkg::angle_lo(limb_q);
	assign rng     = ljn_pkg::angle_range(limb_q);

	assign status.limb_ok = limb_ok;
	assign status.seen    = limb_ok & seen_q[idx];
	assign status.db_pass = (dist_q > deadband_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q     <= ljn_pkg::JUMP_RESET;
			deadband_q <= ljn_pkg::DEADBAND_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ljn_pkg::REG_JUMP_THRESHOLD) begin
				jump_q <= cfg_wdata;
			end else begin
				deadband_q <= cfg_wdata;
			end
		end
	end

	// seen flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.ld_first) begin
			seen_q[idx] <= 1'b1;
		end
	end

	// kept values, written on first sample or on a move
	always_ff @(posedge clk) begin
		if (cmd.ld_first) begin
			kept_mem[idx] <= sample_q;
		end else if (cmd.ld_target) begin
			kept_mem[idx] <= target_d;
		end
	end

	// exact distance to the kept value
	always_comb begin
		diff     = 17'(sample_q) - 17'(kept_rd);
		diff_neg = -diff;
	end

	// distance over three by reciprocal
	assign prod = 33'(dist_q) * 33'(ljn_pkg::RECIP3);

	// jump-limited target
	always_comb begin
		if (dist_q >= jump_q) begin
			target_d = dir_q ? (kept_q + signed'(quot_q)) : (kept_q - signed'(quot_q));
		end else begin
			target_d = sample_q;
		end
	end

	// clamp into the angle range, distance below the top
	always_comb begin
		mag_diff = 17'(target_q) - 17'(lo);
		rng_ext  = signed'({8'b0, rng});
		if (mag_diff < 0) begin
			rest_d = rng;
		end else if (mag_diff > rng_ext) begin
			rest_d = '0;
		end else begin
			rest_d = rng - mag_diff[ljn_pkg::RANGE_W-1:0];
		end
	end

	// dividend with half-up rounding and one restoring divider step
	assign num   = {rest_q, 15'b0} + {15'b0, 1'b0, rng[ljn_pkg::RANGE_W-1:1]};
	assign trial = {1'b0, rem_q, quo_q[ljn_pkg::POS_W-1]} - {2'b0, rng};

	// item and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			limb_q   <= in_data[ljn_pkg::LIMB_W-1:0];
			sample_q <= in_data[ljn_pkg::LIMB_W +: ljn_pkg::SAMPLE_W];
		end
		if (cmd.ld_dist) begin
			kept_q <= kept_rd;
			dir_q  <= ~diff[16];
			dist_q <= diff[16] ? diff_neg[15:0] : diff[15:0];
		end
		if (cmd.ld_quot) begin
			quot_q <= prod[32:17];
		end
		if (cmd.ld_target) begin
			target_q <= target_d;
		end
		if (cmd.ld_rest) begin
			rest_q <= rest_d;
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, num[23:16]};
			quo_q <= num[15:0];
		end else if (cmd.div_step) begin
			if (!trial[10]) begin
				rem_q <= trial[ljn_pkg::RANGE_W-1:0];
				quo_q <= {quo_q[ljn_pkg::POS_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[ljn_pkg::RANGE_W-2:0], quo_q[ljn_pkg::POS_W-1]};
				quo_q <= {quo_q[ljn_pkg::POS_W-2:0], 1'b0};
			end
		end
		if (cmd.ld_out) begin
			out_limb_q <= limb_q;
			out_pos_q  <= quo_q;
		end
	end

	assign out_data = {4'b0, out_pos_q, out_limb_q};

endmodule

[src/limb_jump_limit_deadband_normalizer_unit.sv]
// ----------------------------------------------------------------------------
// limb_jump_limit_deadband_normalizer_unit - per-limb sample filter
// Jump limit and deadband on orientation samples, normalized drive output.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (limb index, signed sample). Result items leave
// on m_axis (limb, Q1.15 drive position); an item gives zero or one result.
// The cfg port writes jump_threshold (index 0) and deadband (index 1);
// write only while the block is idle.
// One item is worked on at a time. An item with a limb index out of range or
// the first sample of a limb goes from the distance state straight to idle, an
// item held by the deadband goes back to idle from the target state, and a moving
// item passes the clamp, the dividend and the 16-step restoring divider that forms
// the normalized position before the output state loads the output register.
// The output register lets the next item be accepted while a result waits;
// if the receiver still stalls when the following result is ready, the block
// holds in its final state and takes no new item until m_axis_tready.
// Reset clears the seen flags of all limbs and loads the register defaults
// (jump_threshold 60, deadband 3); no clearing pass is needed.
// ----------------------------------------------------------------------------
module limb_jump_limit_deadband_normalizer_unit #(
	parameter int NUM_LIMBS = ljn_pkg::NUM_LIMBS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [3:0] limb_index, [19:4] sample_value, [23:20] zero
	input  logic [ljn_pkg::TDATA_W-1:0]    s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] moved_limb, [19:4] drive_position, [23:20] zero
	output logic [ljn_pkg::TDATA_W-1:0]    m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [ljn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ljn_pkg::CFG_W-1:0]      cfg_wdata
);

	ljn_pkg::dp_cmd_t    cmd;
	ljn_pkg::dp_status_t status;

	// sequencing
	ljn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	ljn_dpath #(
		.NUM_LIMBS (NUM_LIMBS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

[src/ljn_checker.sv]
// ----------------------------------------------------------------------------
// ljn_checker - port-level checks of the limb normalizer
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ljn_checker #(
	parameter int NUM_LIMBS = ljn_pkg::NUM_LIMBS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [ljn_pkg::TDATA_W-1:0] s_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [ljn_pkg::TDATA_W-1:0] m_axis_tdata
);

	localparam logic [ljn_pkg::LIMB_W:0] LIMB_CNT = (ljn_pkg::LIMB_W + 1)'(NUM_LIMBS);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one item at a time: an accepted item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input open right after accept");

	// a new result appears only while an item is at work
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without an item at work");

	// result limb in range, position at most one
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ({1'b0, m_axis_tdata[3:0]} < LIMB_CNT)
			&& (m_axis_tdata[19:4] <= 16'd32768) && (m_axis_tdata[23:20] == 4'd0))
		else $error("result field out of range");

endmodule

bind limb_jump_limit_deadband_normalizer_unit ljn_checker #(
	.NUM_LIMBS (NUM_LIMBS)
) u_ljn_checker (.*);
